### design/rvd_pkg.sv
// ----------------------------------------------------------------------------
// rvd_pkg: shared types and constants for the RV32I decode stage
// Opcodes, function codes, ALU and select encodings, flag bit positions,
// and the input and decoded transaction structs.
// ----------------------------------------------------------------------------
package rvd_pkg;

  // Major opcodes
  localparam logic [6:0] OPC_OP       = 7'h33;
  localparam logic [6:0] OPC_OP_IMM   = 7'h13;
  localparam logic [6:0] OPC_LOAD     = 7'h03;
  localparam logic [6:0] OPC_STORE    = 7'h23;
  localparam logic [6:0] OPC_BRANCH   = 7'h63;
  localparam logic [6:0] OPC_LUI      = 7'h37;
  localparam logic [6:0] OPC_AUIPC    = 7'h17;
  localparam logic [6:0] OPC_JAL      = 7'h6f;
  localparam logic [6:0] OPC_JALR     = 7'h67;
  localparam logic [6:0] OPC_SYSTEM   = 7'h73;
  localparam logic [6:0] OPC_MISC_MEM = 7'h0f;

  // funct3 codes for ALU ops
  localparam logic [2:0] F3_ADD_SUB = 3'd0;
  localparam logic [2:0] F3_SLL     = 3'd1;
  localparam logic [2:0] F3_SLT     = 3'd2;
  localparam logic [2:0] F3_SLTU    = 3'd3;
  localparam logic [2:0] F3_XOR     = 3'd4;
  localparam logic [2:0] F3_SRL_SRA = 3'd5;
  localparam logic [2:0] F3_OR      = 3'd6;
  localparam logic [2:0] F3_AND     = 3'd7;

  // funct3 codes for system and fence
  localparam logic [2:0] F3_PRIV   = 3'd0;
  localparam logic [2:0] F3_FENCEI = 3'd1;

  localparam logic [6:0]  FUNCT7_ALT  = 7'h20;
  localparam logic [11:0] SYS_ECALL   = 12'h000;
  localparam logic [11:0] SYS_EBREAK  = 12'h001;
  localparam logic [11:0] SYS_MRET    = 12'h302;

  // ALU operations
  localparam int unsigned ALU_W = 4;
  localparam logic [ALU_W-1:0] ALU_ADD  = 4'd0;
  localparam logic [ALU_W-1:0] ALU_SUB  = 4'd1;
  localparam logic [ALU_W-1:0] ALU_SLL  = 4'd2;
  localparam logic [ALU_W-1:0] ALU_SLT  = 4'd3;
  localparam logic [ALU_W-1:0] ALU_SLTU = 4'd4;
  localparam logic [ALU_W-1:0] ALU_XOR  = 4'd5;
  localparam logic [ALU_W-1:0] ALU_SRL  = 4'd6;
  localparam logic [ALU_W-1:0] ALU_SRA  = 4'd7;
  localparam logic [ALU_W-1:0] ALU_OR   = 4'd8;
  localparam logic [ALU_W-1:0] ALU_AND  = 4'd9;

  // Operand selects: [1:0] source 1, [2] source 2
  localparam logic [1:0] SRC1_RS1  = 2'd0;
  localparam logic [1:0] SRC1_PC   = 2'd1;
  localparam logic [1:0] SRC1_ZERO = 2'd2;
  localparam logic       SRC2_RS2  = 1'b0;
  localparam logic       SRC2_IMM  = 1'b1;

  // Writeback sources
  localparam logic [1:0] WB_ALU = 2'd0;
  localparam logic [1:0] WB_MEM = 2'd1;
  localparam logic [1:0] WB_PC4 = 2'd2;

  // Control flag bit positions
  localparam int unsigned FLAGS_W   = 14;
  localparam int unsigned FL_REGWR  = 0;
  localparam int unsigned FL_MEMRD  = 1;
  localparam int unsigned FL_MEMWR  = 2;
  localparam int unsigned FL_UNS    = 3;
  localparam int unsigned FL_BRANCH = 4;
  localparam int unsigned FL_JUMP   = 5;
  localparam int unsigned FL_ECALL  = 6;
  localparam int unsigned FL_EBREAK = 7;
  localparam int unsigned FL_MRET   = 8;
  localparam int unsigned FL_CSR    = 9;
  localparam int unsigned FL_FENCE  = 10;
  localparam int unsigned FL_FENCEI = 11;
  localparam int unsigned FL_STALL  = 12;
  localparam int unsigned FL_PRED   = 13;

  typedef struct packed {
    logic        inst_valid;
    logic [31:0] instruction;
    logic [31:0] pc;
    logic        pred_taken;
    logic        ex_is_load;
    logic [4:0]  ex_dest_reg;
    logic        ex_stage_valid;
    logic        mem_stage_valid;
    logic        wb_stage_valid;
  } in_item_t;

  typedef struct packed {
    logic               inst_valid;
    logic [4:0]         rs1_index;
    logic [4:0]         rs2_index;
    logic [4:0]         rd_index;
    logic signed [31:0] immediate;
    logic [ALU_W-1:0]   alu_op;
    logic [2:0]         operand_select;
    logic [1:0]         writeback_source;
    logic [FLAGS_W-1:0] control_flags;
    logic [2:0]         funct3;
    logic [11:0]        csr_address;
    logic [31:0]        pc;
  } dec_item_t;

endpackage

### design/rv32i_decode_with_hazard_stall.sv
// ----------------------------------------------------------------------------
// rv32i_decode_with_hazard_stall: RV32I decode stage with hazard stall
// Input register, single-pass decode, result register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one fetched instruction with
//   its pc, prediction bit and the status of the execute, memory and
//   writeback stages. Output channel (out_valid/out_ready) carries exactly
//   one decoded transaction per input transaction, in order.
//   A load-use hazard, or a system/CSR/fence.i instruction while any later
//   stage is valid, yields a bubble: all fields zero except the stall flag.
//   Path: a transaction accepted on the input is captured in the input
//   register, decoded, and then captured in the result register, which
//   drives the output.
//   Throughput: one transaction per cycle while out_ready is high; the path
//   from input register to result register is the decoder alone.
//   Backpressure: while out_ready is low the result register holds; the
//   input register still takes one more transaction, after which in_ready
//   drops until the result is taken.
//   Reset (rst_n low, synchronous) empties both registers.
// ----------------------------------------------------------------------------
module rv32i_decode_with_hazard_stall (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_in_valid,
  input  logic [31:0] in_instruction,
  input  logic [31:0] in_pc,
  input  logic        in_pred_taken,
  input  logic        in_ex_is_load,
  input  logic [4:0]  in_ex_dest_reg,
  input  logic        in_ex_stage_valid,
  input  logic        in_mem_stage_valid,
  input  logic        in_wb_stage_valid,

  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_out_valid,
  output logic [4:0]         out_rs1_index,
  output logic [4:0]         out_rs2_index,
  output logic [4:0]         out_rd_index,
  output logic signed [31:0] out_immediate,
  output logic [3:0]         out_alu_op,
  output logic [2:0]         out_operand_select,
  output logic [1:0]         out_writeback_source,
  output logic [13:0]        out_control_flags,
  output logic [2:0]         out_funct3,
  output logic [11:0]        out_csr_address,
  output logic [31:0]        out_pc_out
);

  rvd_pkg::in_item_t  in_item;
  rvd_pkg::in_item_t  s1_item_r, s1_item_nxt;
  rvd_pkg::dec_item_t dec;
  rvd_pkg::dec_item_t s2_item_r, s2_item_nxt;
  logic               s1_vld_r, s1_vld_nxt;
  logic               s2_vld_r, s2_vld_nxt;
  logic               s1_rdy, s2_rdy;

  assign in_item.inst_valid      = in_in_valid;
  assign in_item.instruction     = in_instruction;
  assign in_item.pc              = in_pc;
  assign in_item.pred_taken      = in_pred_taken;
  assign in_item.ex_is_load      = in_ex_is_load;
  assign in_item.ex_dest_reg     = in_ex_dest_reg;
  assign in_item.ex_stage_valid  = in_ex_stage_valid;
  assign in_item.mem_stage_valid = in_mem_stage_valid;
  assign in_item.wb_stage_valid  = in_wb_stage_valid;

  assign s2_rdy   = !s2_vld_r || out_ready;
  assign s1_rdy   = !s1_vld_r || s2_rdy;
  assign in_ready = s1_rdy;

  rvd_decode u_decode (
    .item_i (s1_item_r),
    .dec_o  (dec)
  );

  always_comb begin
    s1_vld_nxt  = s1_vld_r;
    s1_item_nxt = s1_item_r;
    s2_vld_nxt  = s2_vld_r;
    s2_item_nxt = s2_item_r;
    if (s2_rdy) begin
      s2_vld_nxt  = s1_vld_r;
      s2_item_nxt = dec;
    end
    if (s1_rdy) begin
      s1_vld_nxt  = in_valid;
      s1_item_nxt = in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
    s1_item_r <= s1_item_nxt;
    s2_item_r <= s2_item_nxt;
  end

  assign out_valid            = s2_vld_r;
  assign out_out_valid        = s2_item_r.inst_valid;
  assign out_rs1_index        = s2_item_r.rs1_index;
  assign out_rs2_index        = s2_item_r.rs2_index;
  assign out_rd_index         = s2_item_r.rd_index;
  assign out_immediate        = s2_item_r.immediate;
  assign out_alu_op           = s2_item_r.alu_op;
  assign out_operand_select   = s2_item_r.operand_select;
  assign out_writeback_source = s2_item_r.writeback_source;
  assign out_control_flags    = s2_item_r.control_flags;
  assign out_funct3           = s2_item_r.funct3;
  assign out_csr_address      = s2_item_r.csr_address;
  assign out_pc_out           = s2_item_r.pc;

  // A bubble carries nothing but the stall flag
  a_bubble_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_control_flags[rvd_pkg::FL_STALL]) |->
      (!out_out_valid && out_pc_out == 32'd0 &&
       out_control_flags == (14'd1 << rvd_pkg::FL_STALL)))
    else $error("stall bubble carries payload");

  a_alu_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_alu_op <= rvd_pkg::ALU_AND &&
                   out_writeback_source != 2'd3 &&
                   out_operand_select[1:0] != 2'd3))
    else $error("decoded code out of range");

  // Memory read and write never both; load writes back memory data
  a_mem_ctl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!(out_control_flags[rvd_pkg::FL_MEMRD] &&
                     out_control_flags[rvd_pkg::FL_MEMWR]) &&
                   (out_control_flags[rvd_pkg::FL_MEMRD] ==
                    (out_writeback_source == rvd_pkg::WB_MEM))))
    else $error("inconsistent memory controls");

  // Input register holds a transaction the decoder has not yet passed on
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s2_rdy) |=> (s1_vld_r && $stable(s1_item_r)))
    else $error("input register lost a transaction under backpressure");

endmodule

### design/rvd_decode.sv
// ----------------------------------------------------------------------------
// rvd_decode: RV32I instruction decode and hazard check
// Combinational decode of one instruction into controls, with load-use and
// serializing-instruction stall detection that turns the result into a bubble.
// ----------------------------------------------------------------------------
module rvd_decode (
  input  rvd_pkg::in_item_t  item_i,
  output rvd_pkg::dec_item_t dec_o
);

  logic [31:0] inst;
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [11:0] imm12;

  logic [31:0] imm_i, imm_sh, imm_s, imm_b, imm_u, imm_j;

  logic [31:0]                 imm;
  logic [rvd_pkg::ALU_W-1:0]   alu;
  logic [rvd_pkg::ALU_W-1:0]   alu_base;
  logic [1:0]                  src1;
  logic                        src2;
  logic [1:0]                  wb;
  logic [rvd_pkg::FLAGS_W-1:0] fl;

  logic use_rs1, use_rs2, load_use, serial, stall, later_busy;

  assign inst  = item_i.instruction;
  assign opc   = inst[6:0];
  assign f3    = inst[14:12];
  assign f7    = inst[31:25];
  assign imm12 = inst[31:20];

  assign imm_i  = {{20{inst[31]}}, inst[31:20]};
  assign imm_sh = {27'd0, inst[24:20]};
  assign imm_s  = {{20{inst[31]}}, inst[31:25], inst[11:7]};
  assign imm_b  = {{19{inst[31]}}, inst[31], inst[7], inst[30:25], inst[11:8], 1'b0};
  assign imm_u  = {inst[31:12], 12'd0};
  assign imm_j  = {{11{inst[31]}}, inst[31], inst[19:12], inst[20], inst[30:21], 1'b0};

  // ALU op shared by register and immediate forms; sub is patched in below
  always_comb begin
    unique case (f3)
      rvd_pkg::F3_ADD_SUB: alu_base = rvd_pkg::ALU_ADD;
      rvd_pkg::F3_SLL:     alu_base = rvd_pkg::ALU_SLL;
      rvd_pkg::F3_SLT:     alu_base = rvd_pkg::ALU_SLT;
      rvd_pkg::F3_SLTU:    alu_base = rvd_pkg::ALU_SLTU;
      rvd_pkg::F3_XOR:     alu_base = rvd_pkg::ALU_XOR;
      rvd_pkg::F3_SRL_SRA: alu_base = (f7 == rvd_pkg::FUNCT7_ALT) ? rvd_pkg::ALU_SRA
                                                                  : rvd_pkg::ALU_SRL;
      rvd_pkg::F3_OR:      alu_base = rvd_pkg::ALU_OR;
      default:             alu_base = rvd_pkg::ALU_AND;
    endcase
  end

  always_comb begin
    imm  = '0;
    alu  = rvd_pkg::ALU_ADD;
    src1 = rvd_pkg::SRC1_RS1;
    src2 = rvd_pkg::SRC2_RS2;
    wb   = rvd_pkg::WB_ALU;
    fl   = '0;
    unique case (opc)
      rvd_pkg::OPC_OP: begin
        fl[rvd_pkg::FL_REGWR] = 1'b1;
        alu = alu_base;
        if (f3 == rvd_pkg::F3_ADD_SUB && f7 != 7'd0) alu = rvd_pkg::ALU_SUB;
      end
      rvd_pkg::OPC_OP_IMM: begin
        fl[rvd_pkg::FL_REGWR] = 1'b1;
        src2 = rvd_pkg::SRC2_IMM;
        alu  = alu_base;
        imm  = (f3 == rvd_pkg::F3_SLL || f3 == rvd_pkg::F3_SRL_SRA) ? imm_sh : imm_i;
      end
      rvd_pkg::OPC_LOAD: begin
        src2 = rvd_pkg::SRC2_IMM;
        wb   = rvd_pkg::WB_MEM;
        fl[rvd_pkg::FL_MEMRD] = 1'b1;
        fl[rvd_pkg::FL_REGWR] = 1'b1;
        fl[rvd_pkg::FL_UNS]   = f3[2];
        imm  = imm_i;
      end
      rvd_pkg::OPC_STORE: begin
        src2 = rvd_pkg::SRC2_IMM;
        fl[rvd_pkg::FL_MEMWR] = 1'b1;
        imm  = imm_s;
      end
      rvd_pkg::OPC_BRANCH: begin
        src1 = rvd_pkg::SRC1_PC;
        src2 = rvd_pkg::SRC2_IMM;
        fl[rvd_pkg::FL_BRANCH] = 1'b1;
        imm  = imm_b;
      end
      rvd_pkg::OPC_LUI: begin
        src1 = rvd_pkg::SRC1_ZERO;
        src2 = rvd_pkg::SRC2_IMM;
        fl[rvd_pkg::FL_REGWR] = 1'b1;
        imm  = imm_u;
      end
      rvd_pkg::OPC_AUIPC: begin
        src1 = rvd_pkg::SRC1_PC;
        src2 = rvd_pkg::SRC2_IMM;
        fl[rvd_pkg::FL_REGWR] = 1'b1;
        imm  = imm_u;
      end
      rvd_pkg::OPC_JAL: begin
        src1 = rvd_pkg::SRC1_PC;
        src2 = rvd_pkg::SRC2_IMM;
        wb   = rvd_pkg::WB_PC4;
        fl[rvd_pkg::FL_JUMP]  = 1'b1;
        fl[rvd_pkg::FL_REGWR] = 1'b1;
        imm  = imm_j;
      end
      rvd_pkg::OPC_JALR: begin
        src2 = rvd_pkg::SRC2_IMM;
        wb   = rvd_pkg::WB_PC4;
        fl[rvd_pkg::FL_JUMP]  = 1'b1;
        fl[rvd_pkg::FL_REGWR] = 1'b1;
        imm  = imm_i;
      end
      rvd_pkg::OPC_SYSTEM: begin
        if (f3 == rvd_pkg::F3_PRIV) begin
          // unrecognized privileged encodings set nothing
          fl[rvd_pkg::FL_ECALL]  = (imm12 == rvd_pkg::SYS_ECALL);
          fl[rvd_pkg::FL_EBREAK] = (imm12 == rvd_pkg::SYS_EBREAK);
          fl[rvd_pkg::FL_MRET]   = (imm12 == rvd_pkg::SYS_MRET);
        end else begin
          fl[rvd_pkg::FL_CSR] = 1'b1;
        end
      end
      rvd_pkg::OPC_MISC_MEM: begin
        fl[rvd_pkg::FL_FENCEI] = (f3 == rvd_pkg::F3_FENCEI);
        fl[rvd_pkg::FL_FENCE]  = (f3 != rvd_pkg::F3_FENCEI);
      end
      default: begin
      end
    endcase
  end

  // Unknown opcodes fall to rs1/rs2 selects and so count as reading both
  assign use_rs1 = (src1 == rvd_pkg::SRC1_RS1) || fl[rvd_pkg::FL_BRANCH] ||
                   (opc == rvd_pkg::OPC_JALR);
  assign use_rs2 = (src2 == rvd_pkg::SRC2_RS2) || fl[rvd_pkg::FL_BRANCH] ||
                   fl[rvd_pkg::FL_MEMWR];

  assign load_use = item_i.ex_is_load && (item_i.ex_dest_reg != 5'd0) &&
                    ((use_rs1 && inst[19:15] == item_i.ex_dest_reg) ||
                     (use_rs2 && inst[24:20] == item_i.ex_dest_reg));

  assign later_busy = item_i.ex_stage_valid | item_i.mem_stage_valid |
                      item_i.wb_stage_valid;
  assign serial = later_busy &&
                  (fl[rvd_pkg::FL_ECALL] | fl[rvd_pkg::FL_EBREAK] | fl[rvd_pkg::FL_MRET] |
                   fl[rvd_pkg::FL_FENCEI] | fl[rvd_pkg::FL_CSR]);
  assign stall = load_use | serial;

  always_comb begin
    dec_o = '0;
    if (stall) begin
      dec_o.control_flags[rvd_pkg::FL_STALL] = 1'b1;
    end else begin
      dec_o.inst_valid       = item_i.inst_valid;
      dec_o.rs1_index        = inst[19:15];
      dec_o.rs2_index        = inst[24:20];
      dec_o.rd_index         = inst[11:7];
      dec_o.immediate        = imm;
      dec_o.alu_op           = alu;
      dec_o.operand_select   = {src2, src1};
      dec_o.writeback_source = wb;
      dec_o.control_flags    = fl;
      dec_o.control_flags[rvd_pkg::FL_PRED] = item_i.pred_taken;
      dec_o.funct3           = f3;
      dec_o.csr_address      = imm12;
      dec_o.pc               = item_i.pc;
    end
  end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: RV32I decode stage with hazard stall
// Streams fetched instructions through the decoder with random gaps on the
// input and random stalls on the output. Each input transaction is decoded
// again by an independent predictor and compared field by field with the
// decoded transaction that comes out, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned N_RANDOM   = 450;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned MAX_SHOWN  = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_in_valid = 1'b0;
  logic [31:0] in_instruction = '0;
  logic [31:0] in_pc = '0;
  logic        in_pred_taken = 1'b0;
  logic        in_ex_is_load = 1'b0;
  logic [4:0]  in_ex_dest_reg = '0;
  logic        in_ex_stage_valid = 1'b0;
  logic        in_mem_stage_valid = 1'b0;
  logic        in_wb_stage_valid = 1'b0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_out_valid;
  logic [4:0]         out_rs1_index;
  logic [4:0]         out_rs2_index;
  logic [4:0]         out_rd_index;
  logic signed [31:0] out_immediate;
  logic [3:0]         out_alu_op;
  logic [2:0]         out_operand_select;
  logic [1:0]         out_writeback_source;
  logic [13:0]        out_control_flags;
  logic [2:0]         out_funct3;
  logic [11:0]        out_csr_address;
  logic [31:0]        out_pc_out;

  rv32i_decode_with_hazard_stall dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_in_valid         (in_in_valid),
    .in_instruction      (in_instruction),
    .in_pc               (in_pc),
    .in_pred_taken       (in_pred_taken),
    .in_ex_is_load       (in_ex_is_load),
    .in_ex_dest_reg      (in_ex_dest_reg),
    .in_ex_stage_valid   (in_ex_stage_valid),
    .in_mem_stage_valid  (in_mem_stage_valid),
    .in_wb_stage_valid   (in_wb_stage_valid),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_out_valid       (out_out_valid),
    .out_rs1_index       (out_rs1_index),
    .out_rs2_index       (out_rs2_index),
    .out_rd_index        (out_rd_index),
    .out_immediate       (out_immediate),
    .out_alu_op          (out_alu_op),
    .out_operand_select  (out_operand_select),
    .out_writeback_source(out_writeback_source),
    .out_control_flags   (out_control_flags),
    .out_funct3          (out_funct3),
    .out_csr_address     (out_csr_address),
    .out_pc_out          (out_pc_out)
  );

  always #5 clk = ~clk;

  rvd_pkg::in_item_t  fetch_queue[$];
  rvd_pkg::dec_item_t predicted_decodes[$];

  logic in_acc = 1'b0;
  logic out_acc = 1'b0;
  bit   in_calm = 1'b0;
  bit   out_calm = 1'b0;
  int   in_wait = 0;
  int   out_wait = 0;
  int   n_in = 0;
  int   n_out = 0;
  int   n_bubbles = 0;
  int   n_errors = 0;
  int   idle_cycles = 0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic rvd_pkg::dec_item_t decode_instr(rvd_pkg::in_item_t t);
    rvd_pkg::dec_item_t d;
    logic [31:0] w;
    logic [31:0] imm;
    logic [6:0]  opc;
    logic [6:0]  f7;
    logic [2:0]  f3;
    logic [3:0]  alu;
    logic [1:0]  src1;
    logic [1:0]  wb;
    logic        src2;
    logic        use1;
    logic        use2;
    logic        hazard;
    logic        serial;
    logic [13:0] fl;
    w    = t.instruction;
    opc  = w[6:0];
    f3   = w[14:12];
    f7   = w[31:25];
    imm  = '0;
    alu  = rvd_pkg::ALU_ADD;
    src1 = rvd_pkg::SRC1_RS1;
    src2 = rvd_pkg::SRC2_RS2;
    wb   = rvd_pkg::WB_ALU;
    fl   = '0;
    case (opc)
      rvd_pkg::OPC_OP, rvd_pkg::OPC_OP_IMM: begin
        fl[rvd_pkg::FL_REGWR] = 1'b1;
        case (f3)
          rvd_pkg::F3_ADD_SUB:
            alu = (opc == rvd_pkg::OPC_OP && f7 != 7'h00) ? rvd_pkg::ALU_SUB
                                                          : rvd_pkg::ALU_ADD;
          rvd_pkg::F3_SLL:     alu = rvd_pkg::ALU_SLL;
          rvd_pkg::F3_SLT:     alu = rvd_pkg::ALU_SLT;
          rvd_pkg::F3_SLTU:    alu = rvd_pkg::ALU_SLTU;
          rvd_pkg::F3_XOR:     alu = rvd_pkg::ALU_XOR;
          rvd_pkg::F3_SRL_SRA:
            alu = (f7 == rvd_pkg::FUNCT7_ALT) ? rvd_pkg::ALU_SRA : rvd_pkg::ALU_SRL;
          rvd_pkg::F3_OR:      alu = rvd_pkg::ALU_OR;
          default:             alu = rvd_pkg::ALU_AND;
        endcase
        if (opc == rvd_pkg::OPC_OP_IMM) begin
          src2 = rvd_pkg::SRC2_IMM;
          imm  = {{20{w[31]}}, w[31:20]};
          // shift amounts keep only the shamt field
          if (f3 == rvd_pkg::F3_SLL || f3 == rvd_pkg::F3_SRL_SRA) imm = {27'd0, w[24:20]};
        end
      end
      rvd_pkg::OPC_LOAD: begin
        src2                  = rvd_pkg::SRC2_IMM;
        wb                    = rvd_pkg::WB_MEM;
        fl[rvd_pkg::FL_REGWR] = 1'b1;
        fl[rvd_pkg::FL_MEMRD] = 1'b1;
        fl[rvd_pkg::FL_UNS]   = f3[2];
        imm                   = {{20{w[31]}}, w[31:20]};
      end
      rvd_pkg::OPC_STORE: begin
        src2                  = rvd_pkg::SRC2_IMM;
        fl[rvd_pkg::FL_MEMWR] = 1'b1;
        imm                   = {{20{w[31]}}, w[31:25], w[11:7]};
      end
      rvd_pkg::OPC_BRANCH: begin
        src1                   = rvd_pkg::SRC1_PC;
        src2                   = rvd_pkg::SRC2_IMM;
        fl[rvd_pkg::FL_BRANCH] = 1'b1;
        imm                    = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      end
      rvd_pkg::OPC_LUI, rvd_pkg::OPC_AUIPC: begin
        src1 = (opc == rvd_pkg::OPC_LUI) ? rvd_pkg::SRC1_ZERO : rvd_pkg::SRC1_PC;
        src2                  = rvd_pkg::SRC2_IMM;
        fl[rvd_pkg::FL_REGWR] = 1'b1;
        imm                   = {w[31:12], 12'd0};
      end
      rvd_pkg::OPC_JAL: begin
        src1                  = rvd_pkg::SRC1_PC;
        src2                  = rvd_pkg::SRC2_IMM;
        wb                    = rvd_pkg::WB_PC4;
        fl[rvd_pkg::FL_JUMP]  = 1'b1;
        fl[rvd_pkg::FL_REGWR] = 1'b1;
        imm                   = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      end
      rvd_pkg::OPC_JALR: begin
        src2                  = rvd_pkg::SRC2_IMM;
        wb                    = rvd_pkg::WB_PC4;
        fl[rvd_pkg::FL_JUMP]  = 1'b1;
        fl[rvd_pkg::FL_REGWR] = 1'b1;
        imm                   = {{20{w[31]}}, w[31:20]};
      end
      rvd_pkg::OPC_SYSTEM: begin
        if (f3 == rvd_pkg::F3_PRIV) begin
          case (w[31:20])
            rvd_pkg::SYS_ECALL:  fl[rvd_pkg::FL_ECALL]  = 1'b1;
            rvd_pkg::SYS_EBREAK: fl[rvd_pkg::FL_EBREAK] = 1'b1;
            rvd_pkg::SYS_MRET:   fl[rvd_pkg::FL_MRET]   = 1'b1;
            default:    ;
          endcase
        end else begin
          fl[rvd_pkg::FL_CSR] = 1'b1;
        end
      end
      rvd_pkg::OPC_MISC_MEM: begin
        if (f3 == rvd_pkg::F3_FENCEI) fl[rvd_pkg::FL_FENCEI] = 1'b1;
        else fl[rvd_pkg::FL_FENCE] = 1'b1;
      end
      default: ;
    endcase

    // unknown opcodes keep the rs1/rs2 selects, so both sources count
    use1   = (src1 == rvd_pkg::SRC1_RS1) || fl[rvd_pkg::FL_BRANCH] ||
             (opc == rvd_pkg::OPC_JALR);
    use2   = (src2 == rvd_pkg::SRC2_RS2) || fl[rvd_pkg::FL_BRANCH] ||
             fl[rvd_pkg::FL_MEMWR];
    hazard = t.ex_is_load && (t.ex_dest_reg != 5'd0) &&
             ((use1 && w[19:15] == t.ex_dest_reg) || (use2 && w[24:20] == t.ex_dest_reg));
    serial = (t.ex_stage_valid || t.mem_stage_valid || t.wb_stage_valid) &&
             (fl[rvd_pkg::FL_ECALL] || fl[rvd_pkg::FL_EBREAK] || fl[rvd_pkg::FL_MRET] ||
              fl[rvd_pkg::FL_FENCEI] || fl[rvd_pkg::FL_CSR]);

    d = '0;
    if (hazard || serial) begin
      d.control_flags[rvd_pkg::FL_STALL] = 1'b1;
    end else begin
      fl[rvd_pkg::FL_PRED] = t.pred_taken;
      d.inst_valid       = t.inst_valid;
      d.rs1_index        = w[19:15];
      d.rs2_index        = w[24:20];
      d.rd_index         = w[11:7];
      d.immediate        = imm;
      d.alu_op           = alu;
      d.operand_select   = {src2, src1};
      d.writeback_source = wb;
      d.control_flags    = fl;
      d.funct3           = f3;
      d.csr_address      = w[31:20];
      d.pc               = t.pc;
    end
    return d;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [31:0] enc(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                      logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic rvd_pkg::in_item_t fetch(logic [31:0] inst);
    rvd_pkg::in_item_t t;
    t             = '0;
    t.inst_valid  = 1'b1;
    t.instruction = inst;
    t.pc          = $urandom;
    t.pred_taken  = $urandom_range(0, 1);
    t.ex_dest_reg = $urandom_range(0, 31);
    return t;
  endfunction

  function automatic rvd_pkg::in_item_t random_fetch();
    rvd_pkg::in_item_t t;
    t = fetch($urandom);
    case ($urandom_range(0, 13))
      0:  t.instruction[6:0] = rvd_pkg::OPC_OP;
      1:  t.instruction[6:0] = rvd_pkg::OPC_OP_IMM;
      2:  t.instruction[6:0] = rvd_pkg::OPC_LOAD;
      3:  t.instruction[6:0] = rvd_pkg::OPC_STORE;
      4:  t.instruction[6:0] = rvd_pkg::OPC_BRANCH;
      5:  t.instruction[6:0] = rvd_pkg::OPC_LUI;
      6:  t.instruction[6:0] = rvd_pkg::OPC_AUIPC;
      7:  t.instruction[6:0] = rvd_pkg::OPC_JAL;
      8:  t.instruction[6:0] = rvd_pkg::OPC_JALR;
      9, 10: t.instruction[6:0] = rvd_pkg::OPC_SYSTEM;
      11: t.instruction[6:0] = rvd_pkg::OPC_MISC_MEM;
      default: ;  // raw word, mostly unknown opcodes
    endcase
    if (t.instruction[6:0] == rvd_pkg::OPC_OP || t.instruction[6:0] == rvd_pkg::OPC_OP_IMM) begin
      case ($urandom_range(0, 2))
        0: t.instruction[31:25] = 7'h00;
        1: t.instruction[31:25] = rvd_pkg::FUNCT7_ALT;
        default: ;
      endcase
    end
    if (t.instruction[6:0] == rvd_pkg::OPC_SYSTEM && $urandom_range(0, 1)) begin
      t.instruction[14:12] = rvd_pkg::F3_PRIV;
      case ($urandom_range(0, 3))
        0: t.instruction[31:20] = rvd_pkg::SYS_ECALL;
        1: t.instruction[31:20] = rvd_pkg::SYS_EBREAK;
        2: t.instruction[31:20] = rvd_pkg::SYS_MRET;
        default: ;
      endcase
    end
    if (t.instruction[6:0] == rvd_pkg::OPC_MISC_MEM && $urandom_range(0, 1))
      t.instruction[14:12] = rvd_pkg::F3_FENCEI;

    // steer the execute-stage destination onto the sources often
    t.ex_is_load = ($urandom_range(0, 2) != 0);
    case ($urandom_range(0, 4))
      0: t.ex_dest_reg = t.instruction[19:15];
      1: t.ex_dest_reg = t.instruction[24:20];
      2: t.ex_dest_reg = 5'd0;
      default: ;
    endcase
    if ($urandom_range(0, 2) != 0) begin
      t.ex_stage_valid  = $urandom_range(0, 1);
      t.mem_stage_valid = $urandom_range(0, 1);
      t.wb_stage_valid  = $urandom_range(0, 1);
    end
    t.inst_valid = ($urandom_range(0, 7) != 0);
    return t;
  endfunction

  function automatic string show_decode(rvd_pkg::dec_item_t d);
    return $sformatf(
      "v=%0d rs1=%0d rs2=%0d rd=%0d imm=%h alu=%0d sel=%0d wb=%0d fl=%h f3=%0d csr=%h pc=%h",
      d.inst_valid, d.rs1_index, d.rs2_index, d.rd_index, d.immediate, d.alu_op,
      d.operand_select, d.writeback_source, d.control_flags, d.funct3,
      d.csr_address, d.pc);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: one fetched instruction per transaction, random gaps between
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    rvd_pkg::in_item_t t;
    if (rst_n && (!in_valid || in_acc)) begin
      if (in_valid) begin
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        in_wait = in_calm ? 0 : $urandom_range(0, 17);
      end
      if (in_wait > 0 || fetch_queue.size() == 0) begin
        if (in_wait > 0) in_wait = in_wait - 1;
        in_valid <= 1'b0;
      end else begin
        t = fetch_queue.pop_front();
        in_in_valid        <= t.inst_valid;
        in_instruction     <= t.instruction;
        in_pc              <= t.pc;
        in_pred_taken      <= t.pred_taken;
        in_ex_is_load      <= t.ex_is_load;
        in_ex_dest_reg     <= t.ex_dest_reg;
        in_ex_stage_valid  <= t.ex_stage_valid;
        in_mem_stage_valid <= t.mem_stage_valid;
        in_wb_stage_valid  <= t.wb_stage_valid;
        in_valid           <= 1'b1;
      end
    end
  end

  // Result side backpressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_acc) begin
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        out_wait = out_calm ? 0 : $urandom_range(0, 17);
      end
      if (out_wait > 0) begin
        out_wait = out_wait - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor, checker and watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rvd_pkg::dec_item_t got;
    rvd_pkg::dec_item_t want;
    rvd_pkg::in_item_t  cur;
    in_acc  <= in_valid && in_ready;
    out_acc <= out_valid && out_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_out_valid, out_rs1_index, out_rs2_index, out_rd_index, out_immediate,
               out_alu_op, out_operand_select, out_writeback_source, out_control_flags,
               out_funct3, out_csr_address, out_pc_out};
        n_out = n_out + 1;
        if (got.control_flags[rvd_pkg::FL_STALL]) n_bubbles = n_bubbles + 1;
        if (predicted_decodes.size() == 0) begin
          n_errors = n_errors + 1;
          if (n_errors <= MAX_SHOWN)
            $display("ERROR: unexpected decode transaction: %s", show_decode(got));
        end else begin
          want = predicted_decodes.pop_front();
          if (got !== want) begin
            n_errors = n_errors + 1;
            if (n_errors <= MAX_SHOWN) begin
              $display("ERROR: decode mismatch on transaction %0d", n_out);
              $display("  expected %s", show_decode(want));
              $display("  actual   %s", show_decode(got));
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        cur = {in_in_valid, in_instruction, in_pc, in_pred_taken, in_ex_is_load,
               in_ex_dest_reg, in_ex_stage_valid, in_mem_stage_valid, in_wb_stage_valid};
        predicted_decodes.push_back(decode_instr(cur));
        n_in = n_in + 1;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: no transaction for %0d cycles (%0d in, %0d out)",
                   IDLE_LIMIT, n_in, n_out);
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rvd_pkg::in_item_t t;
    int                n_items;

    // ALU register ops, including odd funct7 values
    t = fetch(enc(7'h00, 5'd31, 5'd0, rvd_pkg::F3_ADD_SUB, 5'd31, rvd_pkg::OPC_OP));
    t.pc = '0;
    fetch_queue.push_back(t);
    t = fetch(enc(rvd_pkg::FUNCT7_ALT, 5'd2, 5'd3, rvd_pkg::F3_ADD_SUB, 5'd4,
                  rvd_pkg::OPC_OP));
    t.pc = '1;
    fetch_queue.push_back(t);
    fetch_queue.push_back(fetch(enc(7'h01, 5'd5, 5'd6, rvd_pkg::F3_ADD_SUB, 5'd7,
                                    rvd_pkg::OPC_OP)));
    fetch_queue.push_back(fetch(enc(7'h01, 5'd8, 5'd9, rvd_pkg::F3_SRL_SRA, 5'd10,
                                    rvd_pkg::OPC_OP)));
    fetch_queue.push_back(fetch(enc(rvd_pkg::FUNCT7_ALT, 5'd11, 5'd12, rvd_pkg::F3_SRL_SRA,
                                    5'd13, rvd_pkg::OPC_OP)));
    fetch_queue.push_back(fetch(enc(7'h7f, 5'd14, 5'd15, rvd_pkg::F3_AND, 5'd16,
                                    rvd_pkg::OPC_OP)));
    // immediates: most negative, shift masking, arithmetic shift
    fetch_queue.push_back(fetch(enc(7'h40, 5'd0, 5'd1, rvd_pkg::F3_ADD_SUB, 5'd2,
                                    rvd_pkg::OPC_OP_IMM)));
    fetch_queue.push_back(fetch(enc(7'h7f, 5'h1f, 5'd7, rvd_pkg::F3_SLL, 5'd7,
                                    rvd_pkg::OPC_OP_IMM)));
    fetch_queue.push_back(fetch(enc(rvd_pkg::FUNCT7_ALT, 5'd13, 5'd3, rvd_pkg::F3_SRL_SRA,
                                    5'd3, rvd_pkg::OPC_OP_IMM)));
    fetch_queue.push_back(fetch(enc(7'h3f, 5'h1f, 5'd5, 3'd4, 5'd6, rvd_pkg::OPC_LOAD)));
    fetch_queue.push_back(fetch(enc(7'h7f, 5'd9, 5'd10, 3'd2, 5'h1f, rvd_pkg::OPC_STORE)));
    t = fetch(enc(7'h40, 5'd1, 5'd2, 3'd1, 5'h01, rvd_pkg::OPC_BRANCH));
    t.pred_taken = 1'b1;
    fetch_queue.push_back(t);
    fetch_queue.push_back(fetch(enc(7'h7f, 5'h1f, 5'h1f, 3'd7, 5'd3, rvd_pkg::OPC_LUI)));
    fetch_queue.push_back(fetch(enc(7'h7f, 5'h1f, 5'h1f, 3'd7, 5'd1, rvd_pkg::OPC_JAL)));
    // jalr reading the register a load is about to write
    t = fetch(enc(7'h00, 5'd0, 5'd8, 3'd0, 5'd1, rvd_pkg::OPC_JALR));
    t.ex_is_load = 1'b1; t.ex_dest_reg = 5'd8;
    fetch_queue.push_back(t);
    // system instructions, with and without busy later stages
    t = fetch(enc(7'h00, 5'd0, 5'd0, rvd_pkg::F3_PRIV, 5'd0, rvd_pkg::OPC_SYSTEM));
    t.mem_stage_valid = 1'b1;
    fetch_queue.push_back(t);
    fetch_queue.push_back(fetch(enc(7'h00, 5'd1, 5'd0, rvd_pkg::F3_PRIV, 5'd0,
                                    rvd_pkg::OPC_SYSTEM)));
    fetch_queue.push_back(fetch(enc(7'h18, 5'd2, 5'd0, rvd_pkg::F3_PRIV, 5'd0,
                                    rvd_pkg::OPC_SYSTEM)));
    fetch_queue.push_back(fetch(enc(7'h08, 5'd5, 5'd0, rvd_pkg::F3_PRIV, 5'd0,
                                    rvd_pkg::OPC_SYSTEM)));
    t = fetch(enc(7'h18, 5'd0, 5'd1, 3'd2, 5'd2, rvd_pkg::OPC_SYSTEM));
    t.wb_stage_valid = 1'b1;
    fetch_queue.push_back(t);
    t = fetch(enc(7'h00, 5'd0, 5'd0, rvd_pkg::F3_FENCEI, 5'd0, rvd_pkg::OPC_MISC_MEM));
    t.ex_stage_valid = 1'b1;
    fetch_queue.push_back(t);
    // plain fence never serializes
    t = fetch(enc(7'h0f, 5'h1f, 5'd0, 3'd0, 5'd0, rvd_pkg::OPC_MISC_MEM));
    t.ex_stage_valid = 1'b1; t.mem_stage_valid = 1'b1; t.wb_stage_valid = 1'b1;
    fetch_queue.push_back(t);
    // unknown opcode counts as reading rs2
    t = fetch(enc(7'h00, 5'd17, 5'd3, 3'd0, 5'd4, 7'h7f));
    t.ex_is_load = 1'b1; t.ex_dest_reg = 5'd17;
    fetch_queue.push_back(t);
    // load into x0 never stalls
    t = fetch(enc(7'h00, 5'd0, 5'd0, rvd_pkg::F3_ADD_SUB, 5'd5, rvd_pkg::OPC_OP));
    t.ex_is_load = 1'b1; t.ex_dest_reg = 5'd0;
    fetch_queue.push_back(t);
    // store data hazard on an invalid slot still bubbles
    t = fetch(enc(7'h00, 5'd12, 5'd1, 3'd2, 5'd0, rvd_pkg::OPC_STORE));
    t.ex_is_load = 1'b1; t.ex_dest_reg = 5'd12; t.inst_valid = 1'b0;
    fetch_queue.push_back(t);
    // lui ignores its rs1 field
    t = fetch(enc(7'h12, 5'd3, 5'd9, 3'd5, 5'd9, rvd_pkg::OPC_LUI));
    t.ex_is_load = 1'b1; t.ex_dest_reg = 5'd9; t.inst_valid = 1'b0;
    fetch_queue.push_back(t);

    repeat (N_RANDOM) fetch_queue.push_back(random_fetch());
    n_items = fetch_queue.size();

    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (n_in < n_items || predicted_decodes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("decoded %0d instructions, %0d results checked, %0d stall bubbles",
             n_in, n_out, n_bubbles);
    $display("mismatches: %0d", n_errors);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
design/rvd_pkg.sv
design/rvd_decode.sv
design/rv32i_decode_with_hazard_stall.sv
sim/testbench.sv
